[hw/rtl/bwtp_pkg.sv]
// Package for the bone world transform block: word types, status codes and
// step encodings shared by the sequencer, the multiply-accumulate unit and the store.
// No dependencies.
`timescale 1ns / 1ps

package bwtp_pkg;

    // One input word: a bone and its local transform, signed Q16.16.
    typedef struct packed {
        logic [7:0]         bone_id;
        logic               has_parent;
        logic [7:0]         parent_id;
        logic [1:0]         inherit_mode;
        logic signed [31:0] local_x;
        logic signed [31:0] local_y;
        logic signed [31:0] local_a;
        logic signed [31:0] local_b;
        logic signed [31:0] local_c;
        logic signed [31:0] local_d;
    } item_word_t;

    // One result word: the bone's world transform and its status.
    typedef struct packed {
        logic [7:0]         out_index;
        logic [1:0]         status;
        logic signed [31:0] world_a;
        logic signed [31:0] world_b;
        logic signed [31:0] world_c;
        logic signed [31:0] world_d;
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
    } result_word_t;

    // One world transform as kept in the store.
    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } xform_t;

    // Result status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MODE   = 2'd1;
    localparam logic [1:0] ST_PARENT = 2'd2;

    // Inherit modes that the block handles.
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_TRANS  = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_SCALE_X = 1'b0;
    localparam logic CFG_SCALE_Y = 1'b1;

    // Output element codes, in the order the sequencer works them.
    localparam logic [2:0] ELEM_A = 3'd0;
    localparam logic [2:0] ELEM_B = 3'd1;
    localparam logic [2:0] ELEM_C = 3'd2;
    localparam logic [2:0] ELEM_D = 3'd3;
    localparam logic [2:0] ELEM_X = 3'd4;
    localparam logic [2:0] ELEM_Y = 3'd5;

    // Control that travels with each operand pair into the multiply-accumulate unit.
    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [2:0] elem;
    } mac_ctl_t;

endpackage

[hw/rtl/bwtp_store.sv]
// World transform store: one write port and one read port with registered read data.
// Depends on bwtp_pkg for the transform type.
`timescale 1ns / 1ps

module bwtp_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  bwtp_pkg::xform_t     wr_data,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    rd_addr,
    output bwtp_pkg::xform_t     rd_data
);

    bwtp_pkg::xform_t mem [DEPTH];
    bwtp_pkg::xform_t rd_data_reg;

    // Write port; entries hold garbage until written.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bwtp_mac.sv]
// Shared multiply-accumulate unit: registered 32x32 product, truncating shift and
// accumulate, then saturation into the six result elements. Depends on bwtp_pkg.
`timescale 1ns / 1ps

module bwtp_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bwtp_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0]  op_p,
    input  logic signed [31:0]  op_q,
    input  logic signed [31:0]  addend,
    output bwtp_pkg::xform_t    result,
    output logic                done
);

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    bwtp_pkg::mac_ctl_t  s1_ctl_reg;
    bwtp_pkg::mac_ctl_t  s2_ctl_reg;
    logic signed [63:0]  mul_reg;
    logic signed [31:0]  add_reg;
    logic signed [63:0]  acc_reg;
    logic signed [63:0]  acc_next;
    logic signed [31:0]  sat_val;
    bwtp_pkg::xform_t    res_reg;
    logic                done_reg;

    // Control pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_ctl_reg <= ctl;
            s2_ctl_reg <= s1_ctl_reg;
            done_reg   <= s2_ctl_reg.valid && s2_ctl_reg.last &&
                          (s2_ctl_reg.elem == bwtp_pkg::ELEM_Y);
        end
    end

    // Stage one: exact product.
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            mul_reg <= $signed(op_p) * $signed(op_q);
            add_reg <= addend;
        end
    end

    // Stage two: the first term of an element starts from its addend.
    always_comb
    begin
        acc_next = (s1_ctl_reg.first ? 64'(add_reg) : acc_reg) + (mul_reg >>> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (s1_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Stage three: clamp the finished sum to 32 bits.
    always_comb
    begin
        if (acc_reg > SAT_MAX)
        begin
            sat_val = SAT_MAX[31:0];
        end
        else if (acc_reg < SAT_MIN)
        begin
            sat_val = SAT_MIN[31:0];
        end
        else
        begin
            sat_val = acc_reg[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ctl_reg.valid && s2_ctl_reg.last)
        begin
            case (s2_ctl_reg.elem)
                bwtp_pkg::ELEM_A: res_reg.a <= sat_val;
                bwtp_pkg::ELEM_B: res_reg.b <= sat_val;
                bwtp_pkg::ELEM_C: res_reg.c <= sat_val;
                bwtp_pkg::ELEM_D: res_reg.d <= sat_val;
                bwtp_pkg::ELEM_X: res_reg.x <= sat_val;
                bwtp_pkg::ELEM_Y: res_reg.y <= sat_val;
                default:          res_reg   <= res_reg;
            endcase
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

[hw/rtl/bone_world_transform_propagate.sv]
// Bone world transform propagation: takes one bone word at a time, parent first, and
// returns its world transform. Built on bwtp_pkg, bwtp_store and bwtp_mac.
`timescale 1ns / 1ps

// A bone word is accepted when the block is idle; its parent entry is read from the
// world store at that edge. For a good word, one shared 32x32 multiplier then works the
// twelve products of the transform one per cycle, the accumulate and saturate stages
// drain, and the delivery state writes the store and loads the result register once the
// output register is free. A rejected word (bad parent, out-of-range bone or unsupported
// inherit mode) goes straight to delivery and leaves the store alone. The next word is
// taken while a result still waits in the output register. Store entries are undefined
// until a bone writes them; there is no clearing pass. The user must write the scale
// registers only while the block is idle; the block itself does not enforce this.
module bone_world_transform_propagate #(
    parameter int MAX_BONES = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  bwtp_pkg::item_word_t    item_data,
    output logic                    result_valid,
    input  logic                    result_ready,
    output bwtp_pkg::result_word_t  result_data,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [31:0]             cfg_data
);

    localparam int ADDR_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam logic [3:0] LAST_STEP = 4'd11;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [3:0]              step_reg;
    bwtp_pkg::item_word_t    item_reg;
    logic [1:0]              status_reg;
    logic                    result_valid_reg;
    bwtp_pkg::result_word_t  result_data_reg;
    logic signed [31:0]      scale_x_reg;
    logic signed [31:0]      scale_y_reg;

    logic                    item_fire;
    logic [1:0]              item_status;
    logic                    slot_free;
    logic                    store_we;
    bwtp_pkg::xform_t        parent_xf;
    bwtp_pkg::xform_t        mac_res;
    logic                    mac_done;
    bwtp_pkg::mac_ctl_t      mac_ctl;
    logic signed [31:0]      op_p;
    logic signed [31:0]      op_q;
    logic signed [31:0]      addend;
    logic [2:0]              elem;
    logic                    term1;
    logic                    row0;
    logic                    col0;
    logic                    is_normal;

    // Map an 8-bit bone index onto the store address.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [7:0] idx);
        logic [ADDR_W+7:0] wide;
        wide = {{ADDR_W{1'b0}}, idx};
        return wide[ADDR_W-1:0];
    endfunction

    assign item_ready   = (state_reg == S_IDLE);
    assign item_fire    = item_valid && item_ready;
    assign slot_free    = !result_valid_reg || result_ready;
    assign store_we     = (state_reg == S_DONE) && slot_free && (status_reg == bwtp_pkg::ST_OK);
    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // Check the incoming word; the parent check comes before the mode check.
    always_comb
    begin
        item_status = bwtp_pkg::ST_OK;
        if ({24'd0, item_data.bone_id} >= 32'(MAX_BONES))
        begin
            item_status = bwtp_pkg::ST_PARENT;
        end
        else if (item_data.has_parent && (item_data.parent_id >= item_data.bone_id))
        begin
            item_status = bwtp_pkg::ST_PARENT;
        end
        else if (item_data.has_parent && (item_data.inherit_mode != bwtp_pkg::MODE_NORMAL) &&
                 (item_data.inherit_mode != bwtp_pkg::MODE_TRANS))
        begin
            item_status = bwtp_pkg::ST_MODE;
        end
    end

    // Scale registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= 32'sd65536;
            scale_y_reg <= 32'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bwtp_pkg::CFG_SCALE_X: scale_x_reg <= cfg_data;
                bwtp_pkg::CFG_SCALE_Y: scale_y_reg <= cfg_data;
                default:               scale_x_reg <= scale_x_reg;
            endcase
        end
    end

    // World store; the parent is read as the word is accepted.
    bwtp_store #(
        .DEPTH  (MAX_BONES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .we      (store_we),
        .wr_addr (to_addr(item_reg.bone_id)),
        .wr_data (mac_res),
        .re      (item_fire),
        .rd_addr (to_addr(item_data.parent_id)),
        .rd_data (parent_xf)
    );

    // Step decode: two terms per output element.
    assign elem      = step_reg[3:1];
    assign term1     = step_reg[0];
    assign row0      = (elem == bwtp_pkg::ELEM_A) || (elem == bwtp_pkg::ELEM_B) ||
                       (elem == bwtp_pkg::ELEM_X);
    assign col0      = (elem == bwtp_pkg::ELEM_A) || (elem == bwtp_pkg::ELEM_C);
    assign is_normal = item_reg.has_parent && (item_reg.inherit_mode == bwtp_pkg::MODE_NORMAL);

    // Operand selection. An unused second term multiplies by zero.
    always_comb
    begin
        op_p   = '0;
        op_q   = '0;
        addend = '0;
        case (elem) inside
            bwtp_pkg::ELEM_A, bwtp_pkg::ELEM_B, bwtp_pkg::ELEM_C, bwtp_pkg::ELEM_D:
            begin
                if (is_normal)
                begin
                    op_p = term1 ? (row0 ? parent_xf.b : parent_xf.d)
                                 : (row0 ? parent_xf.a : parent_xf.c);
                    op_q = term1 ? (col0 ? item_reg.local_c : item_reg.local_d)
                                 : (col0 ? item_reg.local_a : item_reg.local_b);
                end
                else
                begin
                    op_p = row0 ? (col0 ? item_reg.local_a : item_reg.local_b)
                                : (col0 ? item_reg.local_c : item_reg.local_d);
                    op_q = term1 ? 32'sd0 : (row0 ? scale_x_reg : scale_y_reg);
                end
            end
            bwtp_pkg::ELEM_X, bwtp_pkg::ELEM_Y:
            begin
                if (item_reg.has_parent)
                begin
                    op_p   = term1 ? (row0 ? parent_xf.b : parent_xf.d)
                                   : (row0 ? parent_xf.a : parent_xf.c);
                    op_q   = term1 ? item_reg.local_y : item_reg.local_x;
                    addend = row0 ? parent_xf.x : parent_xf.y;
                end
                else
                begin
                    op_p = row0 ? item_reg.local_x : item_reg.local_y;
                    op_q = term1 ? 32'sd0 : (row0 ? scale_x_reg : scale_y_reg);
                end
            end
            default:
            begin
                op_p = '0;
            end
        endcase
    end

    always_comb
    begin
        mac_ctl.valid = (state_reg == S_RUN);
        mac_ctl.first = !term1;
        mac_ctl.last  = term1;
        mac_ctl.elem  = elem;
    end

    bwtp_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .op_p   (op_p),
        .op_q   (op_q),
        .addend (addend),
        .result (mac_res),
        .done   (mac_done)
    );

    // Sequencer and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            item_reg         <= '0;
            status_reg       <= bwtp_pkg::ST_OK;
            result_valid_reg <= 1'b0;
            result_data_reg  <= '0;
        end
        else
        begin
            // A word taken while a new one is loaded is replaced in the delivery state.
            if (result_valid_reg && result_ready && (state_reg != S_DONE))
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_fire)
                    begin
                        item_reg   <= item_data;
                        status_reg <= item_status;
                        step_reg   <= '0;
                        state_reg  <= (item_status == bwtp_pkg::ST_OK) ? S_RUN : S_DONE;
                    end
                end
                S_RUN:
                begin
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == LAST_STEP)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (mac_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        result_valid_reg          <= 1'b1;
                        result_data_reg.out_index <= item_reg.bone_id;
                        result_data_reg.status    <= status_reg;
                        if (status_reg == bwtp_pkg::ST_OK)
                        begin
                            result_data_reg.world_a <= mac_res.a;
                            result_data_reg.world_b <= mac_res.b;
                            result_data_reg.world_c <= mac_res.c;
                            result_data_reg.world_d <= mac_res.d;
                            result_data_reg.world_x <= mac_res.x;
                            result_data_reg.world_y <= mac_res.y;
                        end
                        else
                        begin
                            result_data_reg.world_a <= '0;
                            result_data_reg.world_b <= '0;
                            result_data_reg.world_c <= '0;
                            result_data_reg.world_d <= '0;
                            result_data_reg.world_x <= '0;
                            result_data_reg.world_y <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A store write never meets a parent read of a newly accepted word.
    a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> !item_fire)
        else $error("store write coincides with word acceptance");

    // A rejected word skips the multiplier and goes straight to delivery.
    a_reject_skips_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (item_status != bwtp_pkg::ST_OK)) |=> (state_reg == S_DONE))
        else $error("rejected word did not go straight to delivery");

    // The accumulator finishes its last element only while the sequencer drains.
    a_mac_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_DRAIN))
        else $error("multiply-accumulate finished outside the drain state");

    // Every store write is matched by a good result in the output register.
    a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |=> (result_valid_reg && (result_data_reg.status == bwtp_pkg::ST_OK)))
        else $error("store write without a matching good result");

endmodule
